// ===== src/arh_pkg.sv =====
// ----------------------------------------------------------------------------
// arh_pkg
// Shared constants and codes for the auto-range histogram block.
// ----------------------------------------------------------------------------
package arh_pkg;

  // Default sizing of the block
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_BINS_DEF    = 2048;
  localparam int COUNT_BITS_DEF  = 32;

  // Bin-count register
  localparam int CFG_W      = 12;
  localparam int BINS_RESET = 2048;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_RANGE   = 2'd1,
    OP_HIST    = 2'd2,
    OP_READ    = 2'd3
  } op_e;

endpackage

// ===== src/auto_range_histogram.sv =====
// ----------------------------------------------------------------------------
// auto_range_histogram
// Two-pass histogram: tracks the min/max of range samples, then bins
// histogram samples over that range with saturating counters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  in       | input     | in_valid_i/in_stall_o | op_i, sample_i, bin_select_i
//  out      | output    | out_valid_o/out_stall_i | bin_count_o, bin_hit_o,
//           |           |                      | low_seen_o, high_seen_o,
//           |           |                      | range_known_o
//  cfg      | input     | cfg_we_i             | cfg_data_i (bins in use)
//
// A range request updates the tracked range. A read request does a registered
// read of the bin memory. A histogram request does up to one multiply, then one
// restoring-division step per quotient bit on a shared subtractor, then
// read-modify-write of the bin memory. A restart request runs a memory clearing
// pass over all MAX_BINS bins. After reset the same clearing pass runs before the
// first request is taken. A stalled result holds; one new request may be
// taken while it waits, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module auto_range_histogram
  import arh_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration
  input  logic                        cfg_we_i,
  input  logic [CFG_W-1:0]            cfg_data_i,
  // Request side
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [$clog2(MAX_BINS)-1:0] bin_select_i,
  // Result side
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [COUNT_BITS-1:0]       bin_count_o,
  output logic [$clog2(MAX_BINS)-1:0] bin_hit_o,
  output logic [SAMPLE_BITS-1:0]      low_seen_o,
  output logic [SAMPLE_BITS-1:0]      high_seen_o,
  output logic                        range_known_o
);

  localparam int Q       = $clog2(MAX_BINS);
  localparam int BinsW   = $clog2(MAX_BINS + 1);
  localparam int CmpW    = (CFG_W > BinsW) ? CFG_W : BinsW;
  localparam int ProdW   = SAMPLE_BITS + BinsW;
  localparam int CntW    = $clog2(Q + 1);
  localparam int BinsRst = (BINS_RESET > MAX_BINS) ? MAX_BINS : BINS_RESET;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                 state_q;
  logic [Q-1:0]           mem_addr_q;
  logic                   is_read_q;
  logic                   clr_resp_q;
  logic [BinsW-1:0]       bins_eff_q;
  logic [SAMPLE_BITS-1:0] low_q;
  logic [SAMPLE_BITS-1:0] high_q;
  logic                   known_q;
  logic [SAMPLE_BITS-1:0] diff_q;
  logic [SAMPLE_BITS-1:0] span_q;
  logic [SAMPLE_BITS-1:0] rem_q;
  logic [Q-1:0]           dq_q;
  logic [CntW-1:0]        div_cnt_q;
  logic [COUNT_BITS-1:0]  rdata_q;
  logic [COUNT_BITS-1:0]  res_count_q;
  logic [Q-1:0]           res_hit_q;
  logic                   out_valid_q;

  logic [COUNT_BITS-1:0]  bin_mem_q [MAX_BINS];

  logic                   in_req;
  logic                   out_free;
  logic [BinsW-1:0]       bins_cfg;
  logic [CmpW-1:0]        cfg_ext;
  logic [BinsW-1:0]       bins_m1;
  logic [ProdW-1:0]       prod;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   trial_sub;
  logic                   q_bit;
  logic [Q-1:0]           dq_d;
  logic                   sel_ok;
  logic                   mem_we;
  logic [COUNT_BITS-1:0]  mem_wdata;
  logic [COUNT_BITS-1:0]  count_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_req     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Clamp the written bin count to 1..MAX_BINS
  assign cfg_ext = CmpW'(cfg_data_i);
  always_comb begin
    priority if (cfg_ext == '0) begin
      bins_cfg = BinsW'(1);
    end else if (cfg_ext > CmpW'(MAX_BINS)) begin
      bins_cfg = BinsW'(MAX_BINS);
    end else begin
      bins_cfg = BinsW'(cfg_ext);
    end
  end

  assign bins_m1 = bins_eff_q - BinsW'(1);

  // Scale the offset by the bin count
  assign prod = ProdW'(diff_q) * ProdW'(bins_eff_q);

  // One restoring-division step: bring down the next dividend bit
  assign trial     = {rem_q, dq_q[Q-1]};
  assign trial_sub = trial - {1'b0, span_q};
  assign q_bit     = (trial >= {1'b0, span_q});
  assign dq_d      = Q'({dq_q, q_bit});

  assign sel_ok = ({1'b0, bin_select_i} < BinsW'(MAX_BINS));

  // Saturating increment of the fetched count
  assign count_inc = (rdata_q == '1) ? rdata_q : rdata_q + COUNT_BITS'(1);

  assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_UPD) && !is_read_q);
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : count_inc;

  // Bin counter memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem_q[mem_addr_q] <= mem_wdata;
    end
    if (state_q == S_RD) begin
      rdata_q <= bin_mem_q[mem_addr_q];
    end
  end

  // Bin count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_eff_q <= BinsW'(BinsRst);
    end else if (cfg_we_i) begin
      bins_eff_q <= bins_cfg;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mem_addr_q  <= '0;
      is_read_q   <= 1'b0;
      clr_resp_q  <= 1'b0;
      low_q       <= '1;
      high_q      <= '0;
      known_q     <= 1'b0;
      diff_q      <= '0;
      span_q      <= '0;
      rem_q       <= '0;
      dq_q        <= '0;
      div_cnt_q   <= '0;
      res_count_q <= '0;
      res_hit_q   <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          // Sweep the memory to zero
          mem_addr_q <= mem_addr_q + Q'(1);
          if (mem_addr_q == Q'(MAX_BINS - 1)) begin
            mem_addr_q <= '0;
            clr_resp_q <= 1'b0;
            state_q    <= clr_resp_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_req) begin
            res_count_q <= '0;
            res_hit_q   <= '0;
            unique case (op_e'(op_i))
              OP_RESTART: begin
                low_q      <= '1;
                high_q     <= '0;
                known_q    <= 1'b0;
                mem_addr_q <= '0;
                clr_resp_q <= 1'b1;
                state_q    <= S_CLEAR;
              end
              OP_RANGE: begin
                if (sample_i < low_q) begin
                  low_q <= sample_i;
                end
                if (sample_i > high_q) begin
                  high_q <= sample_i;
                end
                known_q <= 1'b1;
                state_q <= S_DONE;
              end
              OP_HIST: begin
                is_read_q <= 1'b0;
                priority if (!(high_q > low_q) || (sample_i <= low_q)) begin
                  mem_addr_q <= '0;
                  state_q    <= S_RD;
                end else if (sample_i >= high_q) begin
                  mem_addr_q <= bins_m1[Q-1:0];
                  state_q    <= S_RD;
                end else begin
                  diff_q  <= sample_i - low_q;
                  span_q  <= high_q - low_q;
                  state_q <= S_MUL;
                end
              end
              OP_READ: begin
                is_read_q  <= 1'b1;
                mem_addr_q <= bin_select_i;
                state_q    <= sel_ok ? S_RD : S_DONE;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          // Split the product: high part seeds the remainder
          rem_q     <= prod[Q+SAMPLE_BITS-1:Q];
          dq_q      <= prod[Q-1:0];
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          rem_q     <= q_bit ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
          dq_q      <= dq_d;
          div_cnt_q <= div_cnt_q + CntW'(1);
          if (div_cnt_q == CntW'(Q - 1)) begin
            mem_addr_q <= dq_d;
            state_q    <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (is_read_q) begin
            res_count_q <= rdata_q;
          end else begin
            res_hit_q <= mem_addr_q;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      bin_count_o   <= '0;
      bin_hit_o     <= '0;
      low_seen_o    <= '1;
      high_seen_o   <= '0;
      range_known_o <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q   <= 1'b1;
        bin_count_o   <= res_count_q;
        bin_hit_o     <= res_hit_q;
        low_seen_o    <= low_q;
        high_seen_o   <= high_q;
        range_known_o <= known_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/arh_chk.sv =====
// ----------------------------------------------------------------------------
// arh_chk
// Port-level checks for the auto-range histogram, bound to the top level.
// ----------------------------------------------------------------------------
module arh_chk
  import arh_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [COUNT_BITS-1:0]       bin_count_o,
  input logic [$clog2(MAX_BINS)-1:0] bin_hit_o,
  input logic [SAMPLE_BITS-1:0]      low_seen_o,
  input logic [SAMPLE_BITS-1:0]      high_seen_o,
  input logic                        range_known_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_count_o)
      && $stable(bin_hit_o) && $stable(low_seen_o) && $stable(high_seen_o))
    else $error("stalled result changed");

  // Take one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // Never report a count and a hit together
  a_count_or_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bin_count_o == '0) || (bin_hit_o == '0))
    else $error("count and hit both set");

  // Show an empty range until a range sample arrives
  a_empty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !range_known_o |-> (low_seen_o == '1) && (high_seen_o == '0))
    else $error("empty range not shown");

  // Keep the tracked range ordered
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_known_o |-> low_seen_o <= high_seen_o)
    else $error("tracked range inverted");

endmodule

bind auto_range_histogram arh_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .MAX_BINS    (MAX_BINS),
  .COUNT_BITS  (COUNT_BITS)
) u_arh_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .bin_count_o   (bin_count_o),
  .bin_hit_o     (bin_hit_o),
  .low_seen_o    (low_seen_o),
  .high_seen_o   (high_seen_o),
  .range_known_o (range_known_o)
);
